// ===== hw/rtl/fcp_pkg.sv =====
package fcp_pkg;

    // Field widths of the stream words
    localparam int DATA_W = 32;
    localparam int MU_W   = 24;
    localparam int FRAC_W = 16;

    // Square root: radicand and root widths
    localparam int ROOT_W = 32;
    localparam int SQ_W   = 2 * ROOT_W;

    // Packed stream word widths (whole bytes)
    localparam int IN_W  = 120;
    localparam int OUT_W = 104;

    typedef enum logic [1:0] {
        REGION_POLAR    = 2'd0,
        REGION_INSIDE   = 2'd1,
        REGION_BOUNDARY = 2'd2
    } region_t;

    // Input word, first field in the highest bits
    typedef struct packed {
        logic        [MU_W-1:0]   mu;
        logic signed [DATA_W-1:0] tb;
        logic signed [DATA_W-1:0] ta;
        logic signed [DATA_W-1:0] n;
    } item_t;

    // Sideband carried through the normal-component divider
    typedef struct packed {
        region_t             region;
        logic [ROOT_W-1:0]   root;
        item_t               item;
    } np_side_t;

    // Sideband carried through the tangent divider
    typedef struct packed {
        region_t             region;
        logic [DATA_W-1:0]   nsat;
        item_t               item;
    } tan_side_t;

endpackage

// ===== hw/rtl/fcp_sqrt_pipe.sv =====
module fcp_sqrt_pipe #(
    parameter int SIDE_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [fcp_pkg::SQ_W-1:0]    in_rad,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic [fcp_pkg::ROOT_W-1:0]  out_root,
    output logic [SIDE_W-1:0]           out_side
);
    import fcp_pkg::*;

    localparam int REM_W = ROOT_W + 3;

    logic [ROOT_W:0]     vld_reg;
    logic [REM_W-1:0]    rem_reg  [0:ROOT_W];
    logic [SQ_W-1:0]     rad_reg  [0:ROOT_W];
    logic [ROOT_W-1:0]   root_reg [0:ROOT_W];
    logic [SIDE_W-1:0]   side_reg [0:ROOT_W];

    // Advance valid bits with the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[ROOT_W-1:0], in_valid};
        end
    end

    // Load the radicand
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= '0;
            rad_reg[0]  <= in_rad;
            root_reg[0] <= '0;
            side_reg[0] <= in_side;
        end
    end

    // One root bit per stage: bring down two radicand bits, try root*4+1
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        logic [REM_W-1:0] rem_shift;
        logic [REM_W-1:0] trial;
        logic             take;

        assign rem_shift = {rem_reg[k][REM_W-3:0], rad_reg[k][SQ_W-1 -: 2]};
        assign trial     = {{(REM_W-ROOT_W-2){1'b0}}, root_reg[k], 2'b01};
        assign take      = rem_shift >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= take ? (rem_shift - trial) : rem_shift;
                rad_reg[k+1]  <= {rad_reg[k][SQ_W-3:0], 2'b00};
                root_reg[k+1] <= {root_reg[k][ROOT_W-2:0], take};
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W];
    assign out_root  = root_reg[ROOT_W];
    assign out_side  = side_reg[ROOT_W];

endmodule

// ===== hw/rtl/fcp_div_pipe.sv =====
module fcp_div_pipe #(
    parameter int QUO_W  = 32,
    parameter int DIV_W  = 49,
    parameter int SIDE_W = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [DIV_W-1:0]   in_rem,
    input  logic [QUO_W-1:0]   in_low,
    input  logic [DIV_W-1:0]   in_div,
    input  logic [SIDE_W-1:0]  in_side,
    output logic               out_valid,
    output logic [QUO_W-1:0]   out_quo,
    output logic [SIDE_W-1:0]  out_side
);

    logic [QUO_W:0]      vld_reg;
    logic [DIV_W-1:0]    rem_reg  [0:QUO_W];
    logic [QUO_W-1:0]    low_reg  [0:QUO_W];
    logic [QUO_W-1:0]    quo_reg  [0:QUO_W];
    logic [DIV_W-1:0]    div_reg  [0:QUO_W];
    logic [SIDE_W-1:0]   side_reg [0:QUO_W];

    // Advance valid bits with the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[QUO_W-1:0], in_valid};
        end
    end

    // Load the upper dividend as starting remainder
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= in_rem;
            low_reg[0]  <= in_low;
            quo_reg[0]  <= '0;
            div_reg[0]  <= in_div;
            side_reg[0] <= in_side;
        end
    end

    // One quotient bit per stage, restoring
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        logic [DIV_W:0] trial;
        logic [DIV_W:0] diff;
        logic           take;

        assign trial = {rem_reg[k], low_reg[k][QUO_W-1]};
        assign diff  = trial - {1'b0, div_reg[k]};
        assign take  = trial >= {1'b0, div_reg[k]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
                low_reg[k+1]  <= {low_reg[k][QUO_W-2:0], 1'b0};
                quo_reg[k+1]  <= {quo_reg[k][QUO_W-2:0], take};
                div_reg[k+1]  <= div_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[QUO_W];
    assign out_quo   = quo_reg[QUO_W];
    assign out_side  = side_reg[QUO_W];

endmodule

// ===== hw/rtl/friction_cone_projection.sv =====
// Projects a contact reaction (normal n, tangents a, b; signed Q16.16) onto
// the friction cone of coefficient mu (unsigned Q8.16). region tells the case:
// polar (all outputs zero), inside (passed through) or boundary (projected,
// normal saturated to Q16.16, tangents truncated toward zero). The block takes
// one word per clock while the output is not stalled; the result path runs
// through the bit-per-stage square root (33 stages), the normal divider
// (33 stages) and the tangent dividers (41 stages). A stalled output
// freezes the whole pipeline, and the input is ready whenever the output
// register is empty or being taken.
module friction_cone_projection (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // normal_in, tangent_a_in, tangent_b_in, friction_coef
    input  logic [fcp_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // normal_out, tangent_a_out, tangent_b_out, region, zero fill
    output logic [fcp_pkg::OUT_W-1:0] m_tdata
);
    import fcp_pkg::*;

    localparam int NUM_W = MU_W + ROOT_W + 1;
    localparam int DEN_W = 2 * MU_W + 1;
    localparam int G_W   = MU_W + ROOT_W;
    localparam int G_LO  = G_W / 2;
    localparam int P_W   = DATA_W + G_W;
    localparam int D_W   = ROOT_W + FRAC_W;
    localparam int TQ_W  = P_W - D_W;

    function automatic logic [DATA_W-1:0] sat_tan(input logic [TQ_W-1:0] q,
                                                  input logic neg);
        logic big;
        big = q >= {{(TQ_W-DATA_W){1'b0}}, 1'b1, {(DATA_W-1){1'b0}}};
        if (big)
            return neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        else
            return neg ? DATA_W'(-q[DATA_W-1:0]) : q[DATA_W-1:0];
    endfunction

    logic adv;

    logic                 s1_vld_reg;
    item_t                s1_item_reg;
    logic                 s2_vld_reg;
    item_t                s2_item_reg;
    logic [SQ_W-1:0]      s2_aa_reg;
    logic [SQ_W-1:0]      s2_bb_reg;
    logic signed [SQ_W-1:0] sq_a;
    logic signed [SQ_W-1:0] sq_b;
    logic                 s3_vld_reg;
    item_t                s3_item_reg;
    logic [SQ_W-1:0]      s3_sq_reg;

    logic                 rt_vld;
    logic [ROOT_W-1:0]    rt_root;
    item_t                rt_item;

    logic                 s4_vld_reg;
    item_t                s4_item_reg;
    logic [ROOT_W-1:0]    s4_root_reg;
    logic [G_W-1:0]       s4_mt_reg;
    logic signed [NUM_W-1:0] s4_mn_reg;
    logic [2*MU_W-1:0]    s4_mm_reg;
    logic signed [NUM_W-1:0] mn;

    logic signed [NUM_W:0] num_s;
    logic signed [NUM_W:0] t_scaled;
    logic signed [NUM_W:0] mn_ext;
    logic                 polar;
    logic                 in_cone;
    logic                 s5_vld_reg;
    np_side_t             s5_side_reg;
    logic [NUM_W-1:0]     s5_num_reg;
    logic [DEN_W-1:0]     s5_den_reg;

    logic                 np_vld;
    logic [DATA_W-1:0]    np_quo;
    np_side_t             np_side;

    logic                 s6_vld_reg;
    np_side_t             s6_side_reg;
    logic [G_W-1:0]       s6_g_reg;
    logic [DATA_W-1:0]    s6_nsat_reg;

    logic [DATA_W-1:0]    mag_a;
    logic [DATA_W-1:0]    mag_b;
    logic                 s7_vld_reg;
    tan_side_t            s7_side_reg;
    logic [ROOT_W-1:0]    s7_root_reg;
    logic [DATA_W+G_LO-1:0]       s7_pa_lo_reg;
    logic [DATA_W+G_W-G_LO-1:0]   s7_pa_hi_reg;
    logic [DATA_W+G_LO-1:0]       s7_pb_lo_reg;
    logic [DATA_W+G_W-G_LO-1:0]   s7_pb_hi_reg;

    logic                 s8_vld_reg;
    tan_side_t            s8_side_reg;
    logic [P_W-1:0]       s8_pa_reg;
    logic [P_W-1:0]       s8_pb_reg;
    logic [D_W-1:0]       s8_d_reg;

    logic                 ta_vld;
    logic [TQ_W-1:0]      ta_quo;
    tan_side_t            ta_side;
    logic                 tb_vld;
    logic [TQ_W-1:0]      tb_quo;
    logic                 tb_neg;

    logic                 out_vld_reg;
    logic [DATA_W-1:0]    out_n_reg;
    logic [DATA_W-1:0]    out_ta_reg;
    logic [DATA_W-1:0]    out_tb_reg;
    region_t              out_region_reg;

    // Hold the whole pipeline while the output word waits
    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;

    // Advance valid bits of the local stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg  <= s_tvalid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= rt_vld;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= np_vld;
            s7_vld_reg  <= s6_vld_reg;
            s8_vld_reg  <= s7_vld_reg;
            out_vld_reg <= ta_vld && tb_vld;
        end
    end

    // Square the tangents
    assign sq_a = $signed(s1_item_reg.ta) * $signed(s1_item_reg.ta);
    assign sq_b = $signed(s1_item_reg.tb) * $signed(s1_item_reg.tb);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg <= item_t'(s_tdata);
            s2_item_reg <= s1_item_reg;
            s2_aa_reg   <= sq_a;
            s2_bb_reg   <= sq_b;
            s3_item_reg <= s2_item_reg;
            s3_sq_reg   <= s2_aa_reg + s2_bb_reg;
        end
    end

    // Tangential norm
    fcp_sqrt_pipe #(
        .SIDE_W ($bits(item_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s3_vld_reg),
        .in_rad    (s3_sq_reg),
        .in_side   (s3_item_reg),
        .out_valid (rt_vld),
        .out_root  (rt_root),
        .out_side  (rt_item)
    );

    // Form mu*T, mu*n and mu*mu
    assign mn = $signed({1'b0, rt_item.mu}) * $signed(rt_item.n);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_item_reg <= rt_item;
            s4_root_reg <= rt_root;
            s4_mt_reg   <= rt_item.mu * rt_root;
            s4_mn_reg   <= mn;
            s4_mm_reg   <= rt_item.mu * rt_item.mu;
        end
    end

    // Classify: polar when mu*T + n <= 0, inside when T <= mu*n
    assign num_s    = $signed({2'b00, s4_mt_reg})
                    + $signed({{(NUM_W+1-DATA_W-FRAC_W){s4_item_reg.n[DATA_W-1]}},
                               s4_item_reg.n, {FRAC_W{1'b0}}});
    assign t_scaled = $signed({{(NUM_W+1-D_W){1'b0}}, s4_root_reg, {FRAC_W{1'b0}}});
    assign mn_ext   = $signed({s4_mn_reg[NUM_W-1], s4_mn_reg});
    assign polar    = num_s <= 0;
    assign in_cone  = t_scaled <= mn_ext;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            priority if (polar)
                s5_side_reg.region <= REGION_POLAR;
            else if (in_cone)
                s5_side_reg.region <= REGION_INSIDE;
            else
                s5_side_reg.region <= REGION_BOUNDARY;
            s5_side_reg.root <= s4_root_reg;
            s5_side_reg.item <= s4_item_reg;
            s5_num_reg       <= num_s[NUM_W-1:0];
            s5_den_reg       <= {1'b0, s4_mm_reg} + DEN_W'(64'h1_0000_0000);
        end
    end

    // n' = num * 2^16 / (mu*mu + 1)
    fcp_div_pipe #(
        .QUO_W  (DATA_W),
        .DIV_W  (DEN_W),
        .SIDE_W ($bits(np_side_t))
    ) u_div_np (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s5_vld_reg),
        .in_rem    ({{(DEN_W-NUM_W+FRAC_W){1'b0}}, s5_num_reg[NUM_W-1:FRAC_W]}),
        .in_low    ({s5_num_reg[FRAC_W-1:0], {(DATA_W-FRAC_W){1'b0}}}),
        .in_div    (s5_den_reg),
        .in_side   (s5_side_reg),
        .out_valid (np_vld),
        .out_quo   (np_quo),
        .out_side  (np_side)
    );

    // Scale factor g = mu*n', saturate the normal
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_side_reg <= np_side;
            s6_g_reg    <= np_side.item.mu * np_quo;
            s6_nsat_reg <= np_quo[DATA_W-1] ? {1'b0, {(DATA_W-1){1'b1}}} : np_quo;
        end
    end

    // Partial products |t| * g
    assign mag_a = s6_side_reg.item.ta[DATA_W-1] ? DATA_W'(-s6_side_reg.item.ta)
                                                 : DATA_W'(s6_side_reg.item.ta);
    assign mag_b = s6_side_reg.item.tb[DATA_W-1] ? DATA_W'(-s6_side_reg.item.tb)
                                                 : DATA_W'(s6_side_reg.item.tb);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_side_reg.region <= s6_side_reg.region;
            s7_side_reg.nsat   <= s6_nsat_reg;
            s7_side_reg.item   <= s6_side_reg.item;
            s7_root_reg        <= s6_side_reg.root;
            s7_pa_lo_reg       <= mag_a * s6_g_reg[G_LO-1:0];
            s7_pa_hi_reg       <= mag_a * s6_g_reg[G_W-1:G_LO];
            s7_pb_lo_reg       <= mag_b * s6_g_reg[G_LO-1:0];
            s7_pb_hi_reg       <= mag_b * s6_g_reg[G_W-1:G_LO];
        end
    end

    // Sum partial products, form divisor T*2^16
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8_side_reg <= s7_side_reg;
            s8_pa_reg   <= {{(P_W-DATA_W-G_LO){1'b0}}, s7_pa_lo_reg}
                         + {s7_pa_hi_reg, {G_LO{1'b0}}};
            s8_pb_reg   <= {{(P_W-DATA_W-G_LO){1'b0}}, s7_pb_lo_reg}
                         + {s7_pb_hi_reg, {G_LO{1'b0}}};
            s8_d_reg    <= {s7_root_reg, {FRAC_W{1'b0}}};
        end
    end

    // Tangent quotients |t| * g / (T * 2^16)
    fcp_div_pipe #(
        .QUO_W  (TQ_W),
        .DIV_W  (D_W),
        .SIDE_W ($bits(tan_side_t))
    ) u_div_ta (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s8_vld_reg),
        .in_rem    (s8_pa_reg[P_W-1:TQ_W]),
        .in_low    (s8_pa_reg[TQ_W-1:0]),
        .in_div    (s8_d_reg),
        .in_side   (s8_side_reg),
        .out_valid (ta_vld),
        .out_quo   (ta_quo),
        .out_side  (ta_side)
    );

    fcp_div_pipe #(
        .QUO_W  (TQ_W),
        .DIV_W  (D_W),
        .SIDE_W (1)
    ) u_div_tb (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s8_vld_reg),
        .in_rem    (s8_pb_reg[P_W-1:TQ_W]),
        .in_low    (s8_pb_reg[TQ_W-1:0]),
        .in_div    (s8_d_reg),
        .in_side   (s8_side_reg.item.tb[DATA_W-1]),
        .out_valid (tb_vld),
        .out_quo   (tb_quo),
        .out_side  (tb_neg)
    );

    // Select the result by region
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_region_reg <= ta_side.region;
            unique case (ta_side.region)
                REGION_POLAR:
                begin
                    out_n_reg  <= '0;
                    out_ta_reg <= '0;
                    out_tb_reg <= '0;
                end
                REGION_INSIDE:
                begin
                    out_n_reg  <= ta_side.item.n;
                    out_ta_reg <= ta_side.item.ta;
                    out_tb_reg <= ta_side.item.tb;
                end
                default:
                begin
                    out_n_reg  <= ta_side.nsat;
                    out_ta_reg <= sat_tan(ta_quo, ta_side.item.ta[DATA_W-1]);
                    out_tb_reg <= sat_tan(tb_quo, tb_neg);
                end
            endcase
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(OUT_W-3*DATA_W-2){1'b0}}, out_region_reg,
                       out_tb_reg, out_ta_reg, out_n_reg};

    // Projected normal is never negative
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !out_n_reg[DATA_W-1])
        else $error("negative normal in result word");

    // Polar cone gives an all-zero vector
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_region_reg == REGION_POLAR) |->
        (out_n_reg == '0 && out_ta_reg == '0 && out_tb_reg == '0))
        else $error("polar result not zero");

    // Input stalls only behind a waiting output word
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

endmodule
